// ----- rtl/cpbm_pkg.sv -----
// shared types and constants of the chapter page boundary map
package cpbm_pkg;

  // input field widths
  localparam int FUNC_W  = 2;
  localparam int VCHAP_W = 64;
  localparam int CHAP_W  = 10;
  localparam int PAGE_W  = 6;
  localparam int LIST_W  = 16;

  // result field widths
  localparam int FOUND_W  = 6;
  localparam int LOWEST_W = 17;

  // stream payload widths
  localparam int IN_DATA_W  = 96;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 104;
  localparam int OUT_USER_W = 1;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int BPC_W      = 6;
  localparam int LPC_W      = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_BOUNDS_PER_CHAP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LISTS_PER_CHAP  = 2'd1;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_UPDATE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FIND   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_BOUNDS = 2'd2;

  // status codes
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_BAD_PAGE = 1'b1;

  typedef struct packed {
    logic [FOUND_W-1:0]  found;
    logic [LOWEST_W-1:0] lowest;
    logic [LIST_W-1:0]   highest;
    logic                status;
  } res_t;

endpackage

// ----- rtl/chapter_page_boundary_map_core.sv -----
// chapter page boundary map: per-chapter boundary rows in one wide memory
// On the input transfer the chapter's whole row is read from the boundary memory into the
// row register, and an update of a page below the stored boundary count writes its single
// entry; in the read state that follows, the row is compared against the list number in
// parallel and priority encoded (find) or the two page entries are selected (bounds), and
// the result goes into the output register. That register frees the input, so the next
// item is taken while a result waits. Every item, updates too, passes through the read
// state before the input is free again, so no new item is taken while one is in flight;
// an item stays in the read state while the output register still holds an untaken result.
// The boundary memory has no clearing pass after reset; its entries are defined only once written.
module chapter_page_boundary_map_core #(
  parameter int MAX_CHAPTERS   = 1024,
  parameter int MAX_BOUNDARIES = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: virtual_chapter, chapter, page, list_number
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [cpbm_pkg::IN_DATA_W-1:0]     in_tdata,
  // in_tuser: func
  input  logic [cpbm_pkg::IN_USER_W-1:0]     in_tuser,
  // out_tdata: found_page, low_list, high_list, recorded_chapter, zero pad
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [cpbm_pkg::OUT_DATA_W-1:0]    out_tdata,
  // out_tuser: status
  output logic [cpbm_pkg::OUT_USER_W-1:0]    out_tuser,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cpbm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cpbm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int RW = (MAX_CHAPTERS > 1) ? $clog2(MAX_CHAPTERS) : 1;
  localparam int LW = (MAX_BOUNDARIES > 1) ? $clog2(MAX_BOUNDARIES) : 1;

  typedef enum logic {S_IDLE, S_READ} state_t;

  state_t state_r;

  logic [cpbm_pkg::BPC_W-1:0] bpc_r;
  logic [cpbm_pkg::LPC_W-1:0] lpc_r;

  logic [cpbm_pkg::VCHAP_W-1:0] in_vchap;
  logic [cpbm_pkg::CHAP_W-1:0]  in_chap;
  logic [cpbm_pkg::PAGE_W-1:0]  in_page;
  logic [cpbm_pkg::LIST_W-1:0]  in_list;
  logic [cpbm_pkg::FUNC_W-1:0]  in_func;
  logic                         in_fire;
  logic [RW-1:0]                in_row;
  logic [8:0]                   in_page9;
  logic [LW-1:0]                in_lane;
  logic                         mem_we;
  logic                         mem_re;
  logic                         rec_en;

  logic [8:0] e_w;

  logic [MAX_BOUNDARIES-1:0][cpbm_pkg::LIST_W-1:0] mem_q [MAX_CHAPTERS];
  logic [MAX_BOUNDARIES-1:0][cpbm_pkg::LIST_W-1:0] row_r;

  logic [cpbm_pkg::FUNC_W-1:0]  op_func_r;
  logic [cpbm_pkg::PAGE_W-1:0]  op_page_r;
  logic [cpbm_pkg::LIST_W-1:0]  op_list_r;
  logic [cpbm_pkg::VCHAP_W-1:0] vchap_r;

  logic              out_valid_r;
  cpbm_pkg::res_t    res_r;
  cpbm_pkg::res_t    res_w;
  logic [cpbm_pkg::VCHAP_W-1:0] rec_r;

  logic [cpbm_pkg::FOUND_W-1:0]  found_w;
  logic [8:0]                    op_page9;
  logic                          page_bad;
  logic [LW-1:0]                 lo_lane;
  logic [LW-1:0]                 hi_lane;
  logic [cpbm_pkg::LOWEST_W-1:0] lowest_w;
  logic [cpbm_pkg::LIST_W-1:0]   highest_w;
  logic [cpbm_pkg::LIST_W-1:0]   last_list_w;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpc_r <= '0;
      lpc_r <= cpbm_pkg::LPC_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cpbm_pkg::CFG_BOUNDS_PER_CHAP: bpc_r <= cfg_data[cpbm_pkg::BPC_W-1:0];
        cpbm_pkg::CFG_LISTS_PER_CHAP:  lpc_r <= cfg_data[cpbm_pkg::LPC_W-1:0];
        default: ;
      endcase
    end
  end

  // stored boundary count, saturated to the row width
  assign e_w = (9'(bpc_r) > 9'(MAX_BOUNDARIES)) ? 9'(MAX_BOUNDARIES) : 9'(bpc_r);

  // input unpack
  assign in_vchap = in_tdata[63:0];
  assign in_chap  = in_tdata[73:64];
  assign in_page  = in_tdata[79:74];
  assign in_list  = in_tdata[95:80];
  assign in_func  = in_tuser;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign in_page9  = 9'(in_page);
  assign in_lane   = in_page9[LW-1:0];

  assign mem_we = in_fire && (in_func == cpbm_pkg::FUNC_UPDATE) && (in_page9 < e_w);
  assign rec_en = in_fire && (in_func == cpbm_pkg::FUNC_UPDATE) && (in_page9 <= e_w);
  assign mem_re = in_fire &&
                  ((in_func == cpbm_pkg::FUNC_FIND) || (in_func == cpbm_pkg::FUNC_BOUNDS));

  // chapter to row, wrapping at the chapter count
  generate
    if (MAX_CHAPTERS >= 1024) begin : g_row_direct
      assign in_row = RW'(in_chap);
    end else begin : g_row_wrap
      // (upper five bits * 32) mod chapter count
      function automatic logic [319:0] hi_tab_f();
        logic [319:0] t;
        t = '0;
        for (int i = 0; i < 32; i++) begin
          t[i*10 +: 10] = 10'((i * 32) % MAX_CHAPTERS);
        end
        return t;
      endfunction

      localparam logic [319:0] HI_TAB = hi_tab_f();

      logic [10:0] sum_w;
      assign sum_w = 11'(HI_TAB[in_chap[9:5]*10 +: 10]) + 11'(in_chap[4:0]);

      if (MAX_CHAPTERS >= 32) begin : g_sub
        // sum stays below twice the chapter count
        assign in_row = (sum_w >= 11'(MAX_CHAPTERS)) ? RW'(sum_w - 11'(MAX_CHAPTERS))
                                                     : RW'(sum_w);
      end else begin : g_tab
        function automatic logic [383:0] lo_tab_f();
          logic [383:0] t;
          t = '0;
          for (int i = 0; i < 64; i++) begin
            t[i*6 +: 6] = 6'(i % MAX_CHAPTERS);
          end
          return t;
        endfunction

        localparam logic [383:0] LO_TAB = lo_tab_f();

        assign in_row = RW'(LO_TAB[sum_w[5:0]*6 +: 6]);
      end
    end
  endgenerate

  // boundary memory: one row per chapter, single-entry writes, whole-row reads
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_q[in_row][in_lane] <= in_list;
    end
    if (mem_re) begin
      row_r <= mem_q[in_row];
    end
  end

  // last list of the last page
  always_comb begin
    if (lpc_r == '0) begin
      last_list_w = '0;
    end else if (lpc_r > 17'd65536) begin
      last_list_w = '1;
    end else begin
      last_list_w = cpbm_pkg::LIST_W'(lpc_r - 17'd1);
    end
  end

  // find: first stored boundary at or above the list number
  always_comb begin
    found_w = cpbm_pkg::FOUND_W'(e_w);
    for (int p = MAX_BOUNDARIES - 1; p >= 0; p--) begin
      if ((9'(p) < e_w) && (op_list_r <= row_r[p])) begin
        found_w = cpbm_pkg::FOUND_W'(p);
      end
    end
  end

  // bounds: previous page's boundary plus one, this page's boundary or, on the last page, the last list
  assign op_page9  = 9'(op_page_r);
  assign page_bad  = (op_page9 > e_w);
  assign lo_lane   = LW'(op_page9 - 9'd1);
  assign hi_lane   = op_page9[LW-1:0];
  assign lowest_w  = (op_page_r == '0) ? '0
                   : cpbm_pkg::LOWEST_W'(row_r[lo_lane]) + cpbm_pkg::LOWEST_W'(1);
  assign highest_w = (op_page9 < e_w) ? row_r[hi_lane] : last_list_w;

  always_comb begin
    res_w = '0;
    case (op_func_r)
      cpbm_pkg::FUNC_UPDATE: begin
        res_w.status = page_bad ? cpbm_pkg::STATUS_BAD_PAGE : cpbm_pkg::STATUS_OK;
      end
      cpbm_pkg::FUNC_FIND: begin
        res_w.found = found_w;
      end
      cpbm_pkg::FUNC_BOUNDS: begin
        if (page_bad) begin
          res_w.status = cpbm_pkg::STATUS_BAD_PAGE;
        end else begin
          res_w.lowest  = lowest_w;
          res_w.highest = highest_w;
        end
      end
      default: ;
    endcase
  end

  // sequencer, operation registers and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      vchap_r     <= '0;
    end else begin
      if (in_fire) begin
        op_func_r <= in_func;
        op_page_r <= in_page;
        op_list_r <= in_list;
      end
      if (rec_en) begin
        vchap_r <= in_vchap;
      end
      case (state_r)
        S_IDLE: begin
          if (out_valid_r && out_tready) begin
            out_valid_r <= 1'b0;
          end
          if (in_fire) begin
            state_r <= S_READ;
          end
        end
        S_READ: begin
          // hold until the output register is free
          if (!out_valid_r || out_tready) begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
            res_r       <= res_w;
            rec_r       <= vchap_r;
          end
        end
        default: begin
          state_r     <= S_IDLE;
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, rec_r, res_r.highest, res_r.lowest, res_r.found};
  assign out_tuser  = res_r.status;

  // one item in flight at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an item is in flight");

  // a finished row read lands in the output register
  a_result_issued: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) && (!out_valid_r || out_tready) |=> out_valid_r && (state_r == S_IDLE))
    else $error("result not issued after row read");

  // an accepted update within range records its virtual chapter
  a_record: assert property (@(posedge clk) disable iff (!rst_n)
    rec_en |=> (vchap_r == $past(in_vchap)))
    else $error("virtual chapter not recorded");

  // a taken result is not shown again while no new one is ready
  a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && (state_r == S_IDLE) |=> !out_tvalid)
    else $error("result repeated");

endmodule
